>>> design/lrfb_pkg.sv
package lrfb_pkg;

  // Command codes carried in the func field.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_FADE_ENABLE      = 2'd0;
  localparam logic [1:0] REG_FADE_DURATION    = 2'd1;
  localparam logic [1:0] REG_BLINK_BRIGHTNESS = 2'd2;

  localparam logic [15:0] FADE_DURATION_RESET    = 16'd1000;
  localparam logic [7:0]  BLINK_BRIGHTNESS_RESET = 8'd255;

  localparam logic [7:0]  FULL_SCALE      = 8'd255;
  localparam logic [10:0] BLINK_PERIOD_MS = 11'd1000;
  localparam logic [10:0] BLINK_ON_MS     = 11'd500;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FADE_IN,
    PH_FADE_OUT,
    PH_BLINK
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_LOAD,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [23:0] color;
    logic        ring_mode;
    logic        blink;
    logic [31:0] now_ms;
  } cmd_word_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_last;
  } pix_word_t;

endpackage

>>> design/lrfb_serial_div.sv
// Scales an 8-bit channel by num/den with a floor. The product is formed
// in the start cycle, then one quotient bit is retired per cycle. The
// caller guarantees the quotient fits in 8 bits (num <= den).
module lrfb_serial_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  c,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic [7:0]  q,
  output logic        done
);

  logic [23:0] rem;
  logic [23:0] trial;
  logic [2:0]  k;
  logic        busy;

  assign trial = {8'd0, den} << k;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (k == 3'd0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (k == 3'd0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {16'd0, c} * {8'd0, num};
      k   <= 3'd7;
      q   <= 8'd0;
    end else if (busy) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        q[k] <= 1'b1;
      end
      k <= k - 3'd1;
    end
  end

endmodule

>>> design/led_ring_fade_blink_engine_unit.sv
// Channel  Signals                          Word
// -------  -------------------------------  ---------------------------------
// cmd      cmd_valid, cmd_stall, cmd_word   func, color, ring_mode, blink, now
// pix      pix_valid, pix_stall, pix_word   pixel_index, rgb, frame_last
// cfg      cfg_we, cfg_index, cfg_data      fade_enable, duration, brightness
//
// One command word is handled at a time; cmd_stall is high from acceptance
// until the last pixel word of its frame has been taken.
// A frame passes through accept, decode and the serial divider (six channel
// values: three plain and three complemented, each loaded and then divided) and
// then PIXELS output words; a blink tick adds the bit-serial elapsed-modulo-1000
// reduction before the divider. Words that draw nothing return to idle from decode.
// A stall on pix simply holds the current pixel word in place.
// Reset is synchronous and restores the register defaults and an idle ring.
module led_ring_fade_blink_engine_unit #(
  parameter int PIXELS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  lrfb_pkg::cmd_word_t  cmd_word,
  output logic                 pix_valid,
  input  logic                 pix_stall,
  output lrfb_pkg::pix_word_t  pix_word,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam logic [5:0] LAST_PIX = 6'(PIXELS - 1);

  function automatic logic [7:0] chan(input logic [23:0] rgb, input logic [1:0] s);
    case (s)
      2'd0:    chan = rgb[23:16];
      2'd1:    chan = rgb[15:8];
      default: chan = rgb[7:0];
    endcase
  endfunction

  lrfb_pkg::state_t    state;
  lrfb_pkg::state_t    state_next;
  lrfb_pkg::phase_t    phase;
  lrfb_pkg::cmd_word_t cmd;

  // Configuration registers.
  logic        fade_en;
  logic [15:0] fade_dur;
  logic [7:0]  bright;

  // Engine state that persists between command words.
  logic [23:0] held_color;
  logic        comp_mode;
  logic [31:0] start_ms;

  // Frame being built: color, ring mode and the num/den scale factor.
  logic [23:0] frame_rgb;
  logic        frame_comp;
  logic [15:0] frame_num;
  logic [15:0] frame_den;
  logic [23:0] frame_rgb_next;
  logic        frame_comp_next;
  logic [15:0] frame_num_next;
  logic [15:0] frame_den_next;

  // Bit-serial modulo-1000 reduction of the elapsed time.
  logic [31:0] mod_sh;
  logic [9:0]  mod_rem;
  logic [4:0]  mod_cnt;
  logic [10:0] mod_raw;
  logic [10:0] mod_t;

  // Scaled channel values: entries 0..2 plain, 3..5 complemented.
  logic [7:0]  q [6];
  logic [2:0]  j;
  logic [5:0]  pix;
  logic [1:0]  pix_mod3;

  logic [31:0] elapsed;
  logic        fade_done;
  logic        div_start;
  logic        div_done;
  logic [7:0]  div_c;
  logic [7:0]  div_q;
  logic        comp_pix;

  assign elapsed   = cmd.now_ms - start_ms;
  assign fade_done = (fade_dur == 16'd0) || (elapsed >= {16'd0, fade_dur});

  assign mod_raw = {mod_rem, mod_sh[31]};
  assign mod_t   = (mod_raw >= lrfb_pkg::BLINK_PERIOD_MS) ?
                   mod_raw - lrfb_pkg::BLINK_PERIOD_MS : mod_raw;

  assign div_c = (j < 3'd3) ? chan(frame_rgb, j[1:0]) :
                 lrfb_pkg::FULL_SCALE - chan(frame_rgb, 2'(j - 3'd3));

  lrfb_serial_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .c     (div_c),
    .num   (frame_num),
    .den   (frame_den),
    .q     (div_q),
    .done  (div_done)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lrfb_pkg::S_IDLE: begin
        if (cmd_valid) begin
          state_next = lrfb_pkg::S_DECODE;
        end
      end
      lrfb_pkg::S_DECODE: begin
        case (cmd.func)
          lrfb_pkg::FUNC_START: begin
            state_next = (cmd.blink || fade_en) ? lrfb_pkg::S_IDLE : lrfb_pkg::S_LOAD;
          end
          lrfb_pkg::FUNC_STOP: begin
            state_next = fade_en ? lrfb_pkg::S_IDLE : lrfb_pkg::S_LOAD;
          end
          lrfb_pkg::FUNC_TICK: begin
            case (phase)
              lrfb_pkg::PH_IDLE:  state_next = lrfb_pkg::S_IDLE;
              lrfb_pkg::PH_BLINK: state_next = lrfb_pkg::S_MOD;
              default:            state_next = lrfb_pkg::S_LOAD;
            endcase
          end
          default: state_next = lrfb_pkg::S_IDLE;
        endcase
      end
      lrfb_pkg::S_MOD: begin
        if (mod_cnt == 5'd0) begin
          state_next = lrfb_pkg::S_LOAD;
        end
      end
      lrfb_pkg::S_LOAD: state_next = lrfb_pkg::S_DIV;
      lrfb_pkg::S_DIV: begin
        if (div_done) begin
          state_next = (j == 3'd5) ? lrfb_pkg::S_EMIT : lrfb_pkg::S_LOAD;
        end
      end
      lrfb_pkg::S_EMIT: begin
        if (!pix_stall && (pix == LAST_PIX)) begin
          state_next = lrfb_pkg::S_IDLE;
        end
      end
      default: state_next = lrfb_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cmd_stall = (state != lrfb_pkg::S_IDLE);
    pix_valid = (state == lrfb_pkg::S_EMIT);
    div_start = (state == lrfb_pkg::S_LOAD);
  end

  // Frame setup chosen at decode. By default a frame is all zeros at unit
  // scale, which covers the blank frames of stop and of a finished fade out.
  always_comb begin
    frame_rgb_next  = 24'd0;
    frame_comp_next = 1'b0;
    frame_num_next  = 16'd1;
    frame_den_next  = 16'd1;
    case (cmd.func)
      lrfb_pkg::FUNC_START: begin
        frame_rgb_next  = cmd.color;
        frame_comp_next = cmd.ring_mode;
      end
      lrfb_pkg::FUNC_TICK: begin
        case (phase)
          lrfb_pkg::PH_BLINK: begin
            frame_rgb_next = held_color;
            frame_num_next = {8'd0, bright};
            frame_den_next = {8'd0, lrfb_pkg::FULL_SCALE};
          end
          lrfb_pkg::PH_FADE_IN: begin
            frame_rgb_next  = held_color;
            frame_comp_next = comp_mode;
            if (!fade_done) begin
              frame_num_next = elapsed[15:0];
              frame_den_next = fade_dur;
            end
          end
          lrfb_pkg::PH_FADE_OUT: begin
            if (!fade_done) begin
              frame_rgb_next  = held_color;
              frame_comp_next = comp_mode;
              frame_num_next  = fade_dur - elapsed[15:0];
              frame_den_next  = fade_dur;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Pixels whose index is a multiple of three take the complement in ring mode.
  assign comp_pix             = frame_comp && (pix_mod3 == 2'd0);
  assign pix_word.pixel_index = pix;
  assign pix_word.red         = comp_pix ? q[3] : q[0];
  assign pix_word.green       = comp_pix ? q[4] : q[1];
  assign pix_word.blue        = comp_pix ? q[5] : q[2];
  assign pix_word.frame_last  = (pix == LAST_PIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrfb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes must arrive only while the engine is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_en  <= 1'b1;
      fade_dur <= lrfb_pkg::FADE_DURATION_RESET;
      bright   <= lrfb_pkg::BLINK_BRIGHTNESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lrfb_pkg::REG_FADE_ENABLE:      fade_en  <= cfg_data[0];
        lrfb_pkg::REG_FADE_DURATION:    fade_dur <= cfg_data;
        lrfb_pkg::REG_BLINK_BRIGHTNESS: bright   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Phase, held color, ring mode and phase start time.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= lrfb_pkg::PH_IDLE;
      held_color <= 24'd0;
      comp_mode  <= 1'b0;
      start_ms   <= 32'd0;
    end else if (state == lrfb_pkg::S_DECODE) begin
      case (cmd.func)
        lrfb_pkg::FUNC_START: begin
          if (cmd.blink) begin
            held_color <= cmd.color;
            phase      <= lrfb_pkg::PH_BLINK;
            start_ms   <= cmd.now_ms;
          end else begin
            comp_mode <= cmd.ring_mode;
            if (fade_en) begin
              held_color <= cmd.color;
              phase      <= lrfb_pkg::PH_FADE_IN;
              start_ms   <= cmd.now_ms;
            end
          end
        end
        lrfb_pkg::FUNC_STOP: begin
          if (fade_en) begin
            phase    <= lrfb_pkg::PH_FADE_OUT;
            start_ms <= cmd.now_ms;
          end
        end
        lrfb_pkg::FUNC_TICK: begin
          if (((phase == lrfb_pkg::PH_FADE_IN) || (phase == lrfb_pkg::PH_FADE_OUT))
              && fade_done) begin
            phase <= lrfb_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Frame datapath.
  always_ff @(posedge clk) begin
    case (state)
      lrfb_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd <= cmd_word;
        end
      end
      lrfb_pkg::S_DECODE: begin
        frame_rgb  <= frame_rgb_next;
        frame_comp <= frame_comp_next;
        frame_num  <= frame_num_next;
        frame_den  <= frame_den_next;
        mod_sh     <= elapsed;
        mod_rem    <= 10'd0;
        mod_cnt    <= 5'd31;
        j          <= 3'd0;
        pix        <= 6'd0;
        pix_mod3   <= 2'd0;
      end
      lrfb_pkg::S_MOD: begin
        mod_rem <= mod_t[9:0];
        mod_sh  <= mod_sh << 1;
        mod_cnt <= mod_cnt - 5'd1;
        // In the second half of each blink period the ring is dark.
        if ((mod_cnt == 5'd0) && (mod_t >= lrfb_pkg::BLINK_ON_MS)) begin
          frame_rgb <= 24'd0;
        end
      end
      lrfb_pkg::S_DIV: begin
        if (div_done) begin
          q[j] <= div_q;
          j    <= j + 3'd1;
        end
      end
      lrfb_pkg::S_EMIT: begin
        if (!pix_stall) begin
          pix      <= pix + 6'd1;
          pix_mod3 <= (pix_mod3 == 2'd2) ? 2'd0 : pix_mod3 + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/lrfb_checker.sv
module lrfb_checker #(
  parameter int PIXELS = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_stall,
  input lrfb_pkg::cmd_word_t cmd_word,
  input logic                pix_valid,
  input logic                pix_stall,
  input lrfb_pkg::pix_word_t pix_word
);

  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_word))
    else $error("stalled command word changed");

  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pix_word))
    else $error("stalled pixel word changed");

  a_frame_gapless: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall && !pix_word.frame_last |=> pix_valid)
    else $error("gap inside a frame");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_word.frame_last |-> pix_word.pixel_index == 6'(PIXELS - 1))
    else $error("frame ended at the wrong pixel");

  a_no_cmd_during_frame: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> cmd_stall)
    else $error("command accepted while a frame is pending");

endmodule

bind led_ring_fade_blink_engine_unit lrfb_checker #(.PIXELS(PIXELS)) u_lrfb_checker (.*);
